// ===== hdl/indexed_list_insert_defines.svh =====
// assertion macros for the file that carries checks
`ifndef INDEXED_LIST_INSERT_DEFINES_SVH
`define INDEXED_LIST_INSERT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// clocked check, masked while reset is asserted
`define ILI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds while reset is asserted
`define ILI_ASSERT_NR(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ILI_ASSERT(label, prop, msg)
`define ILI_ASSERT_NR(label, prop, msg)
`endif

`endif

// ===== hdl/ili_pkg.sv =====
// shared types and constants of the indexed list insert block
`default_nettype none

package ili_pkg;

    // fixed field widths of the item and result transfers
    localparam int SLOT_IN_W  = 7;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int NEW_SLOT_W = 6;
    localparam int COUNT_W    = 7;

    typedef logic [STATUS_W-1:0] status_t;

    // result status codes
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_FULL    = 2'd1;
    localparam status_t ST_INVALID = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clear_step;
        logic start;
        logic load_err;
        logic rd_idx;
        logic wr1;
        logic wr2;
        logic load_ok;
    } ili_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic clear_last;
        logic reject;
        logic out_free;
    } ili_stat_t;

endpackage

`default_nettype wire

// ===== hdl/ili_in_if.sv =====
// item channel: insert request
`default_nettype none

interface ili_in_if import ili_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 at_head;
    logic [SLOT_IN_W-1:0] after_slot;
    logic [VALUE_W-1:0]   item_value;

    modport source (output valid, at_head, after_slot, item_value, input ready);
    modport sink   (input valid, at_head, after_slot, item_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/ili_out_if.sv =====
// result channel: insert outcome
`default_nettype none

interface ili_out_if import ili_pkg::*; ();
    logic                  valid;
    logic                  ready;
    status_t               status;
    logic [NEW_SLOT_W-1:0] new_slot;
    logic [COUNT_W-1:0]    entry_count;

    modport source (output valid, status, new_slot, entry_count, input ready);
    modport sink   (input valid, status, new_slot, entry_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/ili_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module ili_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ili_ctrl.sv =====
// controller state machine sequencing clear pass and insert steps
`default_nettype none

module ili_ctrl import ili_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire ili_stat_t stat,
    output logic           in_ready,
    output ili_cmd_t       cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RDIDX = 3'd2;
    localparam logic [2:0] S_WR1   = 3'd3;
    localparam logic [2:0] S_WR2   = 3'd4;
    localparam logic [2:0] S_HOLD  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // take an item only when idle and the result register can be reloaded
    assign in_ready = (state_reg == S_IDLE) && stat.out_free;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (stat.reject)
                    begin
                        cmd.load_err = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_RDIDX;
                    end
                end
            end
            S_RDIDX:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_WR1;
            end
            S_WR1:
            begin
                cmd.wr1    = 1'b1;
                state_next = S_WR2;
            end
            S_WR2:
            begin
                cmd.wr2 = 1'b1;
                if (stat.out_free)
                begin
                    cmd.load_ok = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (stat.out_free)
                begin
                    cmd.load_ok = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ili_dpath.sv =====
// datapath: link memories, free and list heads, count and result register
`default_nettype none

module ili_dpath import ili_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ili_cmd_t              cmd,
    output ili_stat_t                  stat,
    input  wire logic                  at_head,
    input  wire logic [SLOT_IN_W-1:0]  after_slot,
    input  wire logic [VALUE_W-1:0]    item_value,
    output status_t                    status,
    output logic      [NEW_SLOT_W-1:0] new_slot,
    output logic      [COUNT_W-1:0]    entry_count,
    output logic                       out_valid,
    input  wire logic                  out_ready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > SLOT_IN_W) ? LW : SLOT_IN_W;
    localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [LW-1:0] free_head_reg, free_head_next;
    logic [LW-1:0] list_head_reg, list_head_next;
    logic [LW-1:0] count_reg, count_next;
    logic [AW-1:0] node_reg, node_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          at_head_reg, at_head_next;
    logic [LW-1:0] follow_reg, follow_next;
    logic          out_valid_reg, out_valid_next;
    status_t       status_reg, status_next;
    logic [NEW_SLOT_W-1:0] slot_reg, slot_next;
    logic [COUNT_W-1:0]    cnt_out_reg, cnt_out_next;

    logic          slot_bad;
    logic          store_full;
    logic [LW-1:0] nx_rdata;
    logic [LW-1:0] nx_clamped;
    logic [LW-1:0] follower;

    logic          nx_we, pv_we, nx_re;
    logic [AW-1:0] nx_waddr, pv_waddr, nx_raddr;
    logic [LW-1:0] nx_wdata, pv_wdata;

    // request checks: range first, then fullness
    assign slot_bad   = !at_head && (CW'(after_slot) >= CW'(CAPACITY));
    assign store_full = (free_head_reg == NULL_LINK);

    assign stat.clear_last = (clr_cnt_reg == LAST_SLOT);
    assign stat.reject     = slot_bad || store_full;
    assign stat.out_free   = !out_valid_reg || out_ready;

    // successor of the popped slot, and the node that will follow the new one
    assign nx_clamped = (nx_rdata < NULL_LINK) ? nx_rdata : NULL_LINK;
    assign follower   = at_head_reg ? list_head_reg : nx_rdata;

    // register next values
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        free_head_next = free_head_reg;
        list_head_next = list_head_reg;
        count_next     = count_reg;
        node_next      = node_reg;
        idx_next       = idx_reg;
        at_head_next   = at_head_reg;
        follow_next    = follow_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        cnt_out_next   = cnt_out_reg;

        if (cmd.clear_step && !stat.clear_last)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end
        if (cmd.start)
        begin
            node_next    = free_head_reg[AW-1:0];
            idx_next     = AW'(after_slot);
            at_head_next = at_head;
        end
        // pop the free slot and count it
        if (cmd.rd_idx)
        begin
            free_head_next = nx_clamped;
            if (count_reg < NULL_LINK)
            begin
                count_next = count_reg + LW'(1);
            end
        end
        if (cmd.wr1)
        begin
            follow_next = follower;
        end
        if (cmd.wr2 && at_head_reg)
        begin
            list_head_next = LW'(node_reg);
        end

        // result register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_err)
        begin
            out_valid_next = 1'b1;
            status_next    = slot_bad ? ST_INVALID : ST_FULL;
            slot_next      = '0;
            cnt_out_next   = COUNT_W'(count_reg);
        end
        if (cmd.load_ok)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            slot_next      = NEW_SLOT_W'(node_reg);
            cnt_out_next   = COUNT_W'(count_reg);
        end
    end

    // next link memory ports
    always_comb
    begin
        nx_we    = 1'b0;
        nx_waddr = clr_cnt_reg;
        nx_wdata = LW'(clr_cnt_reg) + LW'(1);
        if (cmd.clear_step)
        begin
            nx_we = 1'b1;
        end
        else if (cmd.wr1)
        begin
            nx_we    = 1'b1;
            nx_waddr = node_reg;
            nx_wdata = follower;
        end
        else if (cmd.wr2 && !at_head_reg)
        begin
            nx_we    = 1'b1;
            nx_waddr = idx_reg;
            nx_wdata = LW'(node_reg);
        end
        nx_re    = cmd.start || cmd.rd_idx;
        nx_raddr = cmd.rd_idx ? idx_reg : free_head_reg[AW-1:0];
    end

    // prev link memory port
    always_comb
    begin
        pv_we    = 1'b0;
        pv_waddr = clr_cnt_reg;
        pv_wdata = NULL_LINK;
        if (cmd.clear_step)
        begin
            pv_we = 1'b1;
        end
        else if (cmd.wr1)
        begin
            pv_we    = 1'b1;
            pv_waddr = node_reg;
            pv_wdata = at_head_reg ? NULL_LINK : LW'(idx_reg);
        end
        else if (cmd.wr2 && (follow_reg != NULL_LINK))
        begin
            pv_we    = 1'b1;
            pv_waddr = follow_reg[AW-1:0];
            pv_wdata = LW'(node_reg);
        end
    end

    ili_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .re    (nx_re),
        .raddr (nx_raddr),
        .rdata (nx_rdata)
    );

    ili_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .re    (1'b0),
        .raddr ('0),
        .rdata ()
    );

    // payload written into the popped slot as the item is taken
    ili_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_payload_ram (
        .clk   (clk),
        .we    (cmd.start),
        .waddr (free_head_reg[AW-1:0]),
        .wdata (DATA_WIDTH'(item_value)),
        .re    (1'b0),
        .raddr ('0),
        .rdata ()
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            free_head_reg <= '0;
            list_head_reg <= NULL_LINK;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            free_head_reg <= free_head_next;
            list_head_reg <= list_head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        node_reg    <= node_next;
        idx_reg     <= idx_next;
        at_head_reg <= at_head_next;
        follow_reg  <= follow_next;
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign status      = status_reg;
    assign new_slot    = slot_reg;
    assign entry_count = cnt_out_reg;
    assign out_valid   = out_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/indexed_list_insert.sv =====
// top level of the indexed list insert block
//
//  channel  dir  fields                              transfer when
//  req      in   at_head, after_slot, item_value     req.valid && req.ready
//  rsp      out  status, new_slot, entry_count       rsp.valid && rsp.ready
//
// an insert runs these steps from the transfer on: the successor read issued
// with the transfer, read of the follower, node link writes, then splice writes; the
// result loads with the splice writes if the result register is free, else after a hold
// a new insert is not taken until the previous one has loaded its result
// a full store or bad slot loads its result at the transfer edge, valid next cycle
// after reset a clearing pass over every slot rebuilds the links, req.ready low
// a held result blocks a new transfer until the result is taken
`default_nettype none
`include "indexed_list_insert_defines.svh"

module indexed_list_insert import ili_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input wire logic  clk,
    input wire logic  rst_n,
    ili_in_if.sink    req,
    ili_out_if.source rsp
);

    ili_cmd_t  cmd;
    ili_stat_t stat;
    logic      in_ready;

    assign req.ready = in_ready;

    // sequencer
    ili_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // link memories and registers
    ili_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .at_head     (req.at_head),
        .after_slot  (req.after_slot),
        .item_value  (req.item_value),
        .status      (rsp.status),
        .new_slot    (rsp.new_slot),
        .entry_count (rsp.entry_count),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready)
    );

    // checks
    `ILI_ASSERT(a_no_take_in_clear, cmd.clear_step |-> !req.ready, "item taken during clear pass")
    `ILI_ASSERT_NR(a_err_slot_zero, (rsp.valid && rsp.status != ST_OK) |-> (rsp.new_slot == '0), "error result with nonzero slot")
    `ILI_ASSERT(a_no_overwrite, (cmd.load_ok || cmd.load_err) |-> (!rsp.valid || rsp.ready), "result register overwritten")
    `ILI_ASSERT(a_start_then_read, cmd.start |=> cmd.rd_idx, "insert sequence broken after start")

endmodule

`default_nettype wire
